// ===== sv/bmhq_pkg.sv =====
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary min-heap queue.
// ---------------------------------------------------------------------------
package bmhq_pkg;

	localparam int DEPTH = 128;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int KW    = 32;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_POP    = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// memory access request from the sequencer
	typedef struct packed {
		logic              we;
		addr_t             waddr;
		logic signed [KW-1:0] wdata;
		addr_t             raddr_a;
		addr_t             raddr_b;
	} mem_req_t;

endpackage

// ===== sv/bmhq_ram.sv =====
// ---------------------------------------------------------------------------
// bmhq_ram
// Key store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module bmhq_ram (
	input  logic                       clk,
	input  bmhq_pkg::mem_req_t         req,
	output logic signed [31:0]         rdata_a,
	output logic signed [31:0]         rdata_b
);
	import bmhq_pkg::*;

	logic signed [KW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read ports, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[req.raddr_a];
		rdata_b <= mem[req.raddr_b];
	end

endmodule

// ===== sv/bmhq_ctrl.sv =====
// ---------------------------------------------------------------------------
// bmhq_ctrl
// Request sequencer: holds the moving key in a register and walks the tree
// one level at a time (read issue, then compare and write).
// ---------------------------------------------------------------------------
module bmhq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           mode,
	input  logic signed [31:0]   key_in,
	input  logic [6:0]           position,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic signed [31:0]   key_out,
	output logic [1:0]           status,
	output logic [7:0]           count,
	output bmhq_pkg::mem_req_t   mreq,
	input  logic signed [31:0]   rdata_a,
	input  logic signed [31:0]   rdata_b
);
	import bmhq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RD0, S_RD1, S_UPRD, S_UPCMP, S_DNRD, S_DNCMP, S_RSP
	} state_t;

	state_t               state_q;
	cnt_t                 cnt_q;
	addr_t                idx_q;
	logic signed [KW-1:0] mov_q;
	logic signed [KW-1:0] kout_q;
	logic [1:0]           status_q;
	mode_t                mode_q;
	addr_t                pos_q;

	// derived indexes
	logic [AW:0] lc, rc;
	addr_t       par;
	logic        pos_ok;
	assign lc     = {idx_q, 1'b1};
	assign rc     = {idx_q, 1'b0} + (AW+1)'(2);
	assign par    = (idx_q - addr_t'(1)) >> 1;
	assign pos_ok = ({{(CW > 7 ? CW-7 : 0){1'b0}}, position} < (CW > 7 ? CW : 7)'(cnt_q));

	logic l_in, r_in, r_less;
	assign l_in   = lc < (AW+1)'(cnt_q);
	assign r_in   = rc < (AW+1)'(cnt_q);
	assign r_less = r_in && (rdata_b < rdata_a);
	logic signed [KW-1:0] sk;
	assign sk = r_less ? rdata_b : rdata_a;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RSP);
	assign key_out   = kout_q;
	assign status    = status_q;
	assign count     = 8'(cnt_q);

	// memory request
	always_comb begin
		mreq         = '0;
		mreq.wdata   = mov_q;
		mreq.waddr   = idx_q;
		mreq.raddr_a = idx_q;
		mreq.raddr_b = idx_q;
		case (state_q)
			S_IDLE: begin
				mreq.raddr_a = '0;
				mreq.raddr_b = AW'(position);
			end
			S_RD0: begin
				// fetch last entry
				mreq.raddr_a = AW'(cnt_q);
			end
			S_UPRD:  mreq.raddr_a = par;
			S_UPCMP: begin
				mreq.we = 1'b1;
				if (idx_q != '0 && rdata_a > mov_q) mreq.wdata = rdata_a;
			end
			S_DNRD: begin
				mreq.raddr_a = AW'(lc);
				mreq.raddr_b = AW'(rc);
			end
			S_DNCMP: begin
				mreq.we = 1'b1;
				if (l_in && mov_q > sk) mreq.wdata = sk;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			status_q <= ST_OK;
			kout_q   <= '0;
			idx_q    <= '0;
			mov_q    <= '0;
			mode_q   <= MODE_INSERT;
			pos_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (req_valid) begin
					mode_q   <= mode_t'(mode);
					pos_q    <= AW'(position);
					kout_q   <= '0;
					status_q <= ST_OK;
					state_q  <= S_RSP;
					case (mode_t'(mode))
						MODE_INSERT: begin
							if (cnt_q == CW'(DEPTH)) status_q <= ST_FULL;
							else begin
								idx_q   <= AW'(cnt_q);
								mov_q   <= key_in;
								cnt_q   <= cnt_q + 1'b1;
								state_q <= S_UPRD;
							end
						end
						MODE_POP, MODE_PEEK: begin
							if (cnt_q == '0) status_q <= ST_EMPTY;
							else begin
								cnt_q   <= (mode_t'(mode) == MODE_POP) ? cnt_q - 1'b1 : cnt_q;
								state_q <= S_RD0;
							end
						end
						default: begin
							if (!pos_ok) status_q <= ST_RANGE;
							else begin
								cnt_q   <= cnt_q - 1'b1;
								state_q <= S_RD0;
							end
						end
					endcase
				end
				S_RD0: begin
					// root / target data now valid
					if (mode_q == MODE_DELETE) kout_q <= rdata_b;
					else kout_q <= rdata_a;
					if (mode_q == MODE_PEEK) state_q <= S_RSP;
					else if (mode_q == MODE_DELETE && CW'(pos_q) == cnt_q) state_q <= S_RSP;
					else begin
						idx_q   <= (mode_q == MODE_DELETE) ? pos_q : '0;
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					// last entry arrives; check parent for delete
					mov_q   <= rdata_a;
					state_q <= S_UPRD;
					if (mode_q == MODE_POP) state_q <= S_DNRD;
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (idx_q != '0 && rdata_a > mov_q) begin
						idx_q   <= par;
						state_q <= S_UPRD;
					end else if (mode_q == MODE_DELETE && idx_q == pos_q) begin
						state_q <= S_DNRD;
					end else state_q <= S_RSP;
				end
				S_DNRD: state_q <= S_DNCMP;
				S_DNCMP: begin
					if (l_in && mov_q > sk) begin
						idx_q   <= AW'(r_less ? rc : lc);
						state_q <= S_DNRD;
					end else state_q <= S_RSP;
				end
				S_RSP: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RSP && status_q == ST_FULL) |-> cnt_q == CW'(DEPTH))
		else $error("full flagged below depth");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RSP && status_q == ST_EMPTY) |-> cnt_q == '0)
		else $error("empty flagged with entries");
	a_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_RSP) |-> !mreq.we)
		else $error("write while idle");

endmodule

// ===== sv/binary_min_heap_queue.sv =====
// ---------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of signed 32-bit keys in a 128-entry RAM.
// ---------------------------------------------------------------------------
// One request at a time: a new request is taken only after the previous
// response has been transferred, and each level the moved key travels
// costs a registered RAM read and then a compare and write.
// Reset clears the count; RAM contents are undefined and an unwritten entry is never used.
module binary_min_heap_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // mode[1:0], key_in[33:2], position[40:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // key_out[31:0], status[33:32], count[41:34]
);
	import bmhq_pkg::*;

	mem_req_t           mreq;
	logic signed [31:0] rd_a, rd_b, kout;
	logic [1:0]         st;
	logic [7:0]         cnt;

	bmhq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(s_tvalid), .req_ready(s_tready),
		.mode(s_tdata[1:0]), .key_in(s_tdata[33:2]), .position(s_tdata[40:34]),
		.rsp_valid(m_tvalid), .rsp_ready(m_tready),
		.key_out(kout), .status(st), .count(cnt),
		.mreq(mreq), .rdata_a(rd_a), .rdata_b(rd_b)
	);

	bmhq_ram u_ram (.clk(clk), .req(mreq), .rdata_a(rd_a), .rdata_b(rd_b));

	assign m_tdata = {6'd0, cnt, st, kout};

endmodule

// ===== test/heap_checker.sv =====
// ---------------------------------------------------------------------------
// heap_checker
// Watches both stream channels of the heap queue, keeps a shadow heap that
// is updated on every accepted request, and compares each response with the
// oldest predicted one.
// ---------------------------------------------------------------------------
module heap_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,  // mode[1:0], key_in[33:2], position[40:34]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,  // key_out[31:0], status[33:32], count[41:34]
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bmhq_pkg::*;

	typedef struct packed {
		logic signed [31:0] key;
		status_t            status;
		logic [7:0]         count;
	} heap_resp_t;

	logic signed [31:0] shadow [DEPTH];
	int                 n_keys;
	heap_resp_t         resp_q [$];

	assign pending = resp_q.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void swap_keys(input int a, input int b);
		logic signed [31:0] t;
		t = shadow[a];
		shadow[a] = shadow[b];
		shadow[b] = t;
	endfunction

	function automatic void bubble_up(input int i);
		int p;
		while (i > 0 && i < n_keys) begin
			p = (i - 1) / 2;
			if (shadow[p] <= shadow[i]) break;
			swap_keys(p, i);
			i = p;
		end
	endfunction

	function automatic void bubble_down(input int i);
		int l, s;
		while (i < n_keys) begin
			l = 2 * i + 1;
			if (l >= n_keys) break;
			s = l;
			if (l + 1 < n_keys && shadow[l + 1] < shadow[l]) s = l + 1;
			if (shadow[i] <= shadow[s]) break;
			swap_keys(i, s);
			i = s;
		end
	endfunction

	// apply one request to the shadow heap and return the response it causes
	function automatic heap_resp_t heap_apply(input mode_t op, input logic signed [31:0] k,
		input int pos);
		heap_resp_t r;
		r.key = 0;
		r.status = ST_OK;
		case (op)
			MODE_INSERT: begin
				if (n_keys >= DEPTH) r.status = ST_FULL;
				else begin
					shadow[n_keys] = k;
					n_keys++;
					bubble_up(n_keys - 1);
				end
			end
			MODE_POP, MODE_PEEK: begin
				if (n_keys == 0) r.status = ST_EMPTY;
				else begin
					r.key = shadow[0];
					if (op == MODE_POP) begin
						n_keys--;
						shadow[0] = shadow[n_keys];
						bubble_down(0);
					end
				end
			end
			default: begin
				if (pos >= n_keys) r.status = ST_RANGE;
				else begin
					r.key = shadow[pos];
					n_keys--;
					if (pos != n_keys) begin
						shadow[pos] = shadow[n_keys];
						if (pos > 0 && shadow[(pos - 1) / 2] > shadow[pos]) bubble_up(pos);
						else bubble_down(pos);
					end
				end
			end
		endcase
		r.count = n_keys[7:0];
		return r;
	endfunction

	// predict on request transfers, compare on response transfers
	always @(posedge clk or negedge arst_n) begin
		heap_resp_t want;
		if (!arst_n) begin
			n_keys <= 0;
			errors <= 0;
			resp_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				resp_q.push_back(heap_apply(mode_t'(s_tdata[1:0]), s_tdata[33:2],
					int'(s_tdata[40:34])));
			if (m_tvalid && m_tready) begin
				if (resp_q.size() == 0) report("unexpected response", m_tdata[31:0], 0);
				else begin
					want = resp_q.pop_front();
					if (m_tdata[31:0] !== want.key) report("key_out", m_tdata[31:0], want.key);
					if (m_tdata[33:32] !== want.status)
						report("status", m_tdata[33:32], want.status);
					if (m_tdata[41:34] !== want.count)
						report("count", m_tdata[41:34], want.count);
				end
			end
		end
	end
endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives directed and random heap requests with random gaps and response
// back-pressure; the checker predicts and compares every response.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bmhq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;  // mode[1:0], key_in[33:2], position[40:34]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;       // key_out[31:0], status[33:32], count[41:34]
	int          errors;
	int          pending;
	int          live;          // model of the count, for shaping stimulus
	bit          stall_free;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	binary_min_heap_queue DUT (.*);

	heap_checker u_check (.*);

	// send one request, then wait its random gap
	task automatic send(input mode_t op, input logic [31:0] k, input logic [6:0] pos);
		int gap;
		s_tdata <= {7'd0, pos, k, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		case (op)
			MODE_INSERT: if (live < DEPTH) live++;
			MODE_POP:    if (live > 0) live--;
			MODE_DELETE: if (pos < live) live--;
			default: ;
		endcase
		gap = stall_free ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 4))
			0:       return 32'h8000_0000 + $urandom_range(0, 3);
			1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2:       return $urandom_range(0, 15) - 8;
			default: return $urandom();
		endcase
	endfunction

	// response back-pressure: each response waits a random number of cycles
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (m_tvalid) begin
				hold = stall_free ? 0 : $urandom_range(0, 14);
				repeat (hold) @(negedge clk);
				m_tready <= 1'b1;
				@(posedge clk);
				while (!m_tvalid) @(posedge clk);
				@(negedge clk);
				m_tready <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int op;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// empty cases, extremes, duplicates, last-slot delete
		send(MODE_POP, 0, 0);
		send(MODE_PEEK, 0, 0);
		send(MODE_DELETE, 0, 0);
		send(MODE_INSERT, 32'h7FFF_FFFF, 0);
		send(MODE_INSERT, 32'h8000_0000, 0);
		send(MODE_INSERT, 32'h8000_0000, 0);
		send(MODE_INSERT, 32'hFFFF_FFFF, 0);
		send(MODE_INSERT, 32'd5, 0);
		send(MODE_PEEK, 0, 0);
		send(MODE_DELETE, 0, 7'd4);
		send(MODE_DELETE, 0, 7'd127);
		send(MODE_DELETE, 0, 7'd1);
		send(MODE_POP, 0, 0);
		send(MODE_POP, 0, 0);
		send(MODE_POP, 0, 0);
		send(MODE_POP, 0, 0);
		// fill to capacity, overflow, then delete the last and the root entries
		while (live < DEPTH) send(MODE_INSERT, rand_key(), 0);
		send(MODE_INSERT, 32'h1234_5678, 0);
		send(MODE_DELETE, 0, 7'd127);
		send(MODE_DELETE, 0, 7'd0);
		// hold off until every response is back
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// random mix, steered by fill level
		for (int i = 0; i < 750; i++) begin
			stall_free = (i >= 400 && i < 480);
			op = $urandom_range(0, 99);
			if (op < (live < 20 ? 55 : 35)) send(MODE_INSERT, rand_key(), 7'($urandom()));
			else if (op < 65) send(MODE_POP, $urandom(), 7'($urandom()));
			else if (op < 75) send(MODE_PEEK, $urandom(), 7'($urandom()));
			else if (op < 95 && live > 0)
				send(MODE_DELETE, $urandom(), 7'($urandom_range(0, live - 1)));
			else send(MODE_DELETE, $urandom(), 7'($urandom()));
		end
		stall_free = 0;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
